// ===== rtl/iau_pkg.sv =====
// Shared constants, types and helper functions of the interval arithmetic unit.
package iau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int EXT_W      = DATA_WIDTH + 2;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int QW         = (PROD_W - FRAC_BITS > DATA_WIDTH + FRAC_BITS) ?
                              PROD_W - FRAC_BITS : DATA_WIDTH + FRAC_BITS;
  localparam int DIV_STEPS  = QW;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [DATA_WIDTH-1:0]        mag_t;
  typedef logic signed [EXT_W-1:0]      ext_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic [QW-1:0]                quo_t;
  typedef logic [DATA_WIDTH:0]          rem_t;

  localparam ext_t VMAX_EXT = (ext_t'(1) <<< (DATA_WIDTH - 1)) - ext_t'(1);
  localparam ext_t VMIN_EXT = -VMAX_EXT - ext_t'(1);
  localparam logic [QW:0] MAG_MAX = {{(QW + 2 - DATA_WIDTH){1'b0}},
                                     {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [QW:0] MAG_MIN = MAG_MAX + 1'b1;
  localparam prod_t FRAC_MASK = (prod_t'(1) << FRAC_BITS) - prod_t'(1);

  typedef enum logic [4:0] {
    CMD_ADD       = 5'd0,
    CMD_SUB       = 5'd1,
    CMD_MUL       = 5'd2,
    CMD_DIV       = 5'd3,
    CMD_NEG       = 5'd4,
    CMD_WIDTH     = 5'd5,
    CMD_MID       = 5'd6,
    CMD_EQ        = 5'd7,
    CMD_LT        = 5'd8,
    CMD_LE        = 5'd9,
    CMD_GT        = 5'd10,
    CMD_GE        = 5'd11,
    CMD_OVERLAP   = 5'd12,
    CMD_CONTAINS  = 5'd13,
    CMD_POINT     = 5'd14,
    CMD_INTERSECT = 5'd15,
    CMD_UNION     = 5'd16
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ORDER = 3'd1,
    ST_DIVZ  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_OVF   = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e    cmd;
    logic    kill;
    status_e status;
    data_t   al;
    data_t   ah;
    data_t   bl;
    data_t   bh;
    data_t   pt;
  } item_t;

  typedef struct packed {
    cmd_e       cmd;
    logic       kill;
    status_e    status;
    logic       flag;
    ext_t       lo;
    ext_t       hi;
    mag_t       dl;
    mag_t       dh;
    logic [3:0] neg;
  } meta_t;

  typedef struct packed {
    rem_t rem;
    quo_t nq;
  } lane_t;

  function automatic mag_t mag_of(data_t x);
    mag_t m;
    m = x[DATA_WIDTH-1] ? mag_t'(-x) : mag_t'(x);
    return m;
  endfunction

  function automatic lane_t div_step(lane_t l, mag_t d);
    rem_t  r;
    lane_t o;
    r    = {l.rem[DATA_WIDTH-1:0], l.nq[QW-1]};
    o.nq = {l.nq[QW-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      r       = r - {1'b0, d};
      o.nq[0] = 1'b1;
    end
    o.rem = r;
    return o;
  endfunction

  function automatic ext_t clamp_pos(logic [QW:0] m);
    ext_t v;
    v = (m > MAG_MAX) ? VMAX_EXT + ext_t'(1) : ext_t'(m);
    return v;
  endfunction

  function automatic ext_t clamp_neg(logic [QW:0] m);
    ext_t v;
    v = (m > MAG_MIN) ? VMIN_EXT - ext_t'(1) : -ext_t'(m);
    return v;
  endfunction

endpackage

// ===== rtl/interval_arithmetic_unit.sv =====
// Top level of the interval arithmetic unit: front end, item queue and back end.
// The unit takes one item per clock while the pipeline is not stalled and
// returns one result per item, in order. Every item, whatever its opcode, runs
// through the same back-end pipeline of 51 register stages; the length is set
// by the divider, which resolves one quotient bit per stage for the four
// corner quotients in parallel. A full output register stalls the whole
// pipeline, and the two-entry queue lets the front end take up to two more
// transfers meanwhile. The unit holds no state between items.
module interval_arithmetic_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [4:0]     cmd_i,
  input  iau_pkg::data_t a_low_i,
  input  iau_pkg::data_t a_high_i,
  input  iau_pkg::data_t b_low_i,
  input  iau_pkg::data_t b_high_i,
  input  iau_pkg::data_t point_value_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output iau_pkg::data_t res_low_o,
  output iau_pkg::data_t res_high_o,
  output logic           test_flag_o,
  output logic [2:0]     status_o
);
  import iau_pkg::*;

  logic  push, push_ready, pop_valid, pop;
  item_t push_item, pop_item;

  iau_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .a_low_i       (a_low_i),
    .a_high_i      (a_high_i),
    .b_low_i       (b_low_i),
    .b_high_i      (b_high_i),
    .point_value_i (point_value_i),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .item_o        (push_item)
  );

  iau_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .item_i       (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .item_o       (pop_item)
  );

  iau_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (pop_valid),
    .pop_o        (pop),
    .item_i       (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_low_o    (res_low_o),
    .res_high_o   (res_high_o),
    .test_flag_o  (test_flag_o),
    .res_status_o (status_o)
  );

endmodule

// ===== rtl/iau_front.sv =====
// Front end: accepts items and classifies them before they enter the queue.
module iau_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [4:0]       cmd_i,
  input  iau_pkg::data_t   a_low_i,
  input  iau_pkg::data_t   a_high_i,
  input  iau_pkg::data_t   b_low_i,
  input  iau_pkg::data_t   b_high_i,
  input  iau_pkg::data_t   point_value_i,
  output logic             push_o,
  input  logic             push_ready_i,
  output iau_pkg::item_t   item_o
);
  import iau_pkg::*;

  logic known, uses_b, err_order, err_divz;

  always_comb begin
    known     = (cmd_i <= CMD_UNION);
    uses_b    = !(cmd_i == CMD_NEG || cmd_i == CMD_WIDTH || cmd_i == CMD_MID ||
                  cmd_i == CMD_POINT);
    err_order = (a_low_i > a_high_i) || (uses_b && (b_low_i > b_high_i));
    err_divz  = (cmd_i == CMD_DIV) && (b_low_i <= data_t'(0)) && (b_high_i >= data_t'(0));

    item_o.kill   = !known || err_order || err_divz;
    item_o.cmd    = item_o.kill ? CMD_ADD : cmd_e'(cmd_i);
    item_o.status = !known ? ST_OK : err_order ? ST_ORDER : err_divz ? ST_DIVZ : ST_OK;
    item_o.al     = a_low_i;
    item_o.ah     = a_high_i;
    item_o.bl     = b_low_i;
    item_o.bh     = b_high_i;
    item_o.pt     = point_value_i;
  end

  assign push_o     = in_valid_i;
  assign in_ready_o = push_ready_i;

endmodule

// ===== rtl/iau_fifo.sv =====
// Short queue of classified items between the front end and the back end.
module iau_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  iau_pkg::item_t item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output iau_pkg::item_t item_o
);
  import iau_pkg::*;

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// ===== rtl/iau_back.sv =====
// Back end: pipelined execution of the operations with a registered output.
module iau_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fifo_valid_i,
  output logic           pop_o,
  input  iau_pkg::item_t item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output iau_pkg::data_t res_low_o,
  output iau_pkg::data_t res_high_o,
  output logic           test_flag_o,
  output logic [2:0]     res_status_o
);
  import iau_pkg::*;

  logic adv;

  meta_t m0_d;
  prod_t p0_d [4];

  logic  s1_v_q;
  meta_t s1_meta_q;
  prod_t s1_p_q [4];

  lane_t init_lane [4];

  logic [DIV_STEPS-1:0] st_v_q;
  meta_t                st_meta_q [DIV_STEPS];
  lane_t                st_lane_q [DIV_STEPS][4];
  lane_t                st_lane_d [DIV_STEPS][4];

  logic  r_v_q;
  meta_t r_meta_q;
  ext_t  r_fl_q [4];
  ext_t  r_cl_q [4];
  ext_t  fl_d [4];
  ext_t  cl_d [4];

  logic    out_v_q;
  data_t   out_lo_q, out_hi_q;
  logic    out_flag_q;
  status_e out_st_q;

  ext_t    fin_lo, fin_hi, min01, min23, max01, max23;
  data_t   o_lo_d, o_hi_d;
  logic    o_flag_d, ov;
  status_e o_st_d;

  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = adv && fifo_valid_i;

  always_comb begin
    ext_t al, ah, bl, bh, mx, mn;
    data_t x, y;
    al = ext_t'(item_i.al);
    ah = ext_t'(item_i.ah);
    bl = ext_t'(item_i.bl);
    bh = ext_t'(item_i.bh);
    mx = '0;
    mn = '0;
    m0_d        = '0;
    m0_d.cmd    = item_i.cmd;
    m0_d.kill   = item_i.kill;
    m0_d.status = item_i.status;
    m0_d.dl     = mag_of(item_i.bl);
    m0_d.dh     = mag_of(item_i.bh);
    for (int k = 0; k < 4; k++) begin
      x = (k % 2 == 1) ? item_i.ah : item_i.al;
      y = (k / 2 == 1) ? item_i.bh : item_i.bl;
      m0_d.neg[k] = x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1];
      if (item_i.cmd == CMD_MUL) begin
        p0_d[k] = prod_t'(mag_of(x)) * prod_t'(mag_of(y));
      end else begin
        p0_d[k] = prod_t'(mag_of(x)) << FRAC_BITS;
      end
    end
    if (!item_i.kill) begin
      case (item_i.cmd)
        CMD_ADD: begin
          m0_d.lo = al + bl;
          m0_d.hi = ah + bh;
        end
        CMD_SUB: begin
          m0_d.lo = al - bh;
          m0_d.hi = ah - bl;
        end
        CMD_NEG: begin
          m0_d.lo = -ah;
          m0_d.hi = -al;
        end
        CMD_WIDTH:    m0_d.lo = ah - al;
        CMD_MID:      m0_d.lo = (al + ah) >>> 1;
        CMD_EQ:       m0_d.flag = (al == bl) && (ah == bh);
        CMD_LT:       m0_d.flag = ah < bl;
        CMD_LE:       m0_d.flag = ah <= bl;
        CMD_GT:       m0_d.flag = bh < al;
        CMD_GE:       m0_d.flag = bh <= al;
        CMD_OVERLAP:  m0_d.flag = (al <= bh) && (bl <= ah);
        CMD_CONTAINS: m0_d.flag = (al <= bl) && (bh <= ah);
        CMD_POINT:    m0_d.flag = (item_i.al <= item_i.pt) && (item_i.pt <= item_i.ah);
        CMD_INTERSECT: begin
          mx = (al > bl) ? al : bl;
          mn = (ah < bh) ? ah : bh;
          if (mx > mn) begin
            m0_d.status = ST_EMPTY;
          end else begin
            m0_d.lo = mx;
            m0_d.hi = mn;
          end
        end
        CMD_UNION: begin
          m0_d.lo = (al < bl) ? al : bl;
          m0_d.hi = (ah > bh) ? ah : bh;
        end
        default: begin
          m0_d.lo = '0;
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (s1_meta_q.cmd == CMD_DIV) begin
        init_lane[k].rem = '0;
        init_lane[k].nq  = quo_t'(s1_p_q[k]);
      end else begin
        init_lane[k].rem = rem_t'((s1_p_q[k] & FRAC_MASK) != '0);
        init_lane[k].nq  = quo_t'(s1_p_q[k] >> FRAC_BITS);
      end
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int k = 0; k < 4; k++) begin
        if (j == 0) begin
          st_lane_d[j][k] = (s1_meta_q.cmd == CMD_DIV) ?
            div_step(init_lane[k], (k / 2 == 1) ? s1_meta_q.dh : s1_meta_q.dl) :
            init_lane[k];
        end else begin
          st_lane_d[j][k] = (st_meta_q[j-1].cmd == CMD_DIV) ?
            div_step(st_lane_q[j-1][k],
                     (k / 2 == 1) ? st_meta_q[j-1].dh : st_meta_q[j-1].dl) :
            st_lane_q[j-1][k];
        end
      end
    end
  end

  always_comb begin
    logic [QW:0] q0, q1;
    logic        inx;
    for (int k = 0; k < 4; k++) begin
      inx = (st_lane_q[DIV_STEPS-1][k].rem != '0);
      q0  = {1'b0, st_lane_q[DIV_STEPS-1][k].nq};
      q1  = q0 + (QW+1)'(inx);
      if (st_meta_q[DIV_STEPS-1].neg[k]) begin
        fl_d[k] = clamp_neg(q1);
        cl_d[k] = clamp_neg(q0);
      end else begin
        fl_d[k] = clamp_pos(q0);
        cl_d[k] = clamp_pos(q1);
      end
    end
  end

  always_comb begin
    min01 = (r_fl_q[1] < r_fl_q[0]) ? r_fl_q[1] : r_fl_q[0];
    min23 = (r_fl_q[3] < r_fl_q[2]) ? r_fl_q[3] : r_fl_q[2];
    max01 = (r_cl_q[1] > r_cl_q[0]) ? r_cl_q[1] : r_cl_q[0];
    max23 = (r_cl_q[3] > r_cl_q[2]) ? r_cl_q[3] : r_cl_q[2];
    if (r_meta_q.cmd == CMD_MUL || r_meta_q.cmd == CMD_DIV) begin
      fin_lo = (min23 < min01) ? min23 : min01;
      fin_hi = (max23 > max01) ? max23 : max01;
    end else begin
      fin_lo = r_meta_q.lo;
      fin_hi = r_meta_q.hi;
    end
    ov = 1'b0;
    if (fin_lo > VMAX_EXT) begin
      o_lo_d = data_t'(VMAX_EXT);
      ov     = 1'b1;
    end else if (fin_lo < VMIN_EXT) begin
      o_lo_d = data_t'(VMIN_EXT);
      ov     = 1'b1;
    end else begin
      o_lo_d = data_t'(fin_lo);
    end
    if (fin_hi > VMAX_EXT) begin
      o_hi_d = data_t'(VMAX_EXT);
      ov     = 1'b1;
    end else if (fin_hi < VMIN_EXT) begin
      o_hi_d = data_t'(VMIN_EXT);
      ov     = 1'b1;
    end else begin
      o_hi_d = data_t'(fin_hi);
    end
    o_flag_d = r_meta_q.flag;
    o_st_d   = r_meta_q.status;
    if (r_meta_q.kill || r_meta_q.status != ST_OK) begin
      o_lo_d   = '0;
      o_hi_d   = '0;
      o_flag_d = 1'b0;
    end else if (ov) begin
      o_st_d = ST_OVF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q <= m0_d;
      for (int k = 0; k < 4; k++) begin
        s1_p_q[k] <= p0_d[k];
        r_fl_q[k] <= fl_d[k];
        r_cl_q[k] <= cl_d[k];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        st_meta_q[j] <= (j == 0) ? s1_meta_q : st_meta_q[(j == 0) ? 0 : j - 1];
        for (int k = 0; k < 4; k++) begin
          st_lane_q[j][k] <= st_lane_d[j][k];
        end
      end
      r_meta_q   <= st_meta_q[DIV_STEPS-1];
      out_lo_q   <= o_lo_d;
      out_hi_q   <= o_hi_d;
      out_flag_q <= o_flag_d;
      out_st_q   <= o_st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      st_v_q  <= '0;
      r_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= fifo_valid_i;
      st_v_q  <= {st_v_q[DIV_STEPS-2:0], s1_v_q};
      r_v_q   <= st_v_q[DIV_STEPS-1];
      out_v_q <= r_v_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign res_low_o    = out_lo_q;
  assign res_high_o   = out_hi_q;
  assign test_flag_o  = out_flag_q;
  assign res_status_o = out_st_q;

endmodule

// ===== test/iau_checker.sv =====
// Result predictor and scoreboard of the interval arithmetic unit test bench.
module iau_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  logic [4:0]     cmd_i,
  input  iau_pkg::data_t a_low_i,
  input  iau_pkg::data_t a_high_i,
  input  iau_pkg::data_t b_low_i,
  input  iau_pkg::data_t b_high_i,
  input  iau_pkg::data_t point_value_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  iau_pkg::data_t res_low_i,
  input  iau_pkg::data_t res_high_i,
  input  logic           test_flag_i,
  input  logic [2:0]     status_i,
  output int             fail_count_o,
  output int             pending_o
);
  import iau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VMAX_L = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint VMIN_L = -VMAX_L - 1;

  typedef struct packed {
    data_t   lo;
    data_t   hi;
    logic    flag;
    status_e status;
  } interval_res_t;

  interval_res_t expected_q[$];

  function automatic data_t saturate(longint v, ref bit ovf);
    data_t d;
    if (v > VMAX_L) begin
      ovf = 1'b1;
      d = data_t'(VMAX_L);
    end else if (v < VMIN_L) begin
      ovf = 1'b1;
      d = data_t'(VMIN_L);
    end else begin
      d = data_t'(v);
    end
    return d;
  endfunction

  function automatic interval_res_t interval_result(logic [4:0] c, data_t al_i, data_t ah_i,
                                                    data_t bl_i, data_t bh_i, data_t pt_i);
    interval_res_t r;
    longint al, ah, bl, bh, pt, lo, hi, x, y, t, f, cl, q, rm;
    bit uses_b, ovf;
    al = al_i;
    ah = ah_i;
    bl = bl_i;
    bh = bh_i;
    pt = pt_i;
    r = '0;
    r.status = ST_OK;
    lo = 0;
    hi = 0;
    ovf = 1'b0;
    uses_b = !(c inside {CMD_NEG, CMD_WIDTH, CMD_MID, CMD_POINT});
    if (c > CMD_UNION) return r;
    if (al > ah || (uses_b && bl > bh)) begin
      r.status = ST_ORDER;
      return r;
    end
    if (c == CMD_DIV && bl <= 0 && bh >= 0) begin
      r.status = ST_DIVZ;
      return r;
    end
    case (cmd_e'(c))
      CMD_ADD: begin lo = al + bl; hi = ah + bh; end
      CMD_SUB: begin lo = al - bh; hi = ah - bl; end
      CMD_MUL, CMD_DIV: begin
        for (int k = 0; k < 4; k++) begin
          x = (k & 1) ? ah : al;
          y = (k & 2) ? bh : bl;
          if (c == CMD_MUL) begin
            t  = x * y;
            f  = t >>> FRAC_BITS;
            cl = -((-t) >>> FRAC_BITS);
          end else begin
            t  = x <<< FRAC_BITS;
            q  = t / y;
            rm = t % y;
            f  = q - ((rm != 0 && ((t < 0) != (y < 0))) ? 1 : 0);
            cl = q + ((rm != 0 && ((t < 0) == (y < 0))) ? 1 : 0);
          end
          if (k == 0 || f < lo) lo = f;
          if (k == 0 || cl > hi) hi = cl;
        end
      end
      CMD_NEG: begin lo = -ah; hi = -al; end
      CMD_WIDTH: lo = ah - al;
      CMD_MID: lo = (al + ah) >>> 1;
      CMD_EQ: r.flag = (al == bl) && (ah == bh);
      CMD_LT: r.flag = ah < bl;
      CMD_LE: r.flag = ah <= bl;
      CMD_GT: r.flag = bh < al;
      CMD_GE: r.flag = bh <= al;
      CMD_OVERLAP: r.flag = (al <= bh) && (bl <= ah);
      CMD_CONTAINS: r.flag = (al <= bl) && (bh <= ah);
      CMD_POINT: r.flag = (al <= pt) && (pt <= ah);
      CMD_INTERSECT: begin
        lo = (al > bl) ? al : bl;
        hi = (ah < bh) ? ah : bh;
        if (lo > hi) begin
          r.status = ST_EMPTY;
          return r;
        end
      end
      default: begin
        lo = (al < bl) ? al : bl;
        hi = (ah > bh) ? ah : bh;
      end
    endcase
    r.lo = saturate(lo, ovf);
    r.hi = saturate(hi, ovf);
    if (ovf) r.status = ST_OVF;
    return r;
  endfunction

  initial fail_count_o = 0;
  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    interval_res_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(interval_result(cmd_i, a_low_i, a_high_i, b_low_i, b_high_i,
                                             point_value_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer lo=%h hi=%h flag=%b status=%0d", $time,
                   res_low_i, res_high_i, test_flag_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (res_low_i !== e.lo || res_high_i !== e.hi || test_flag_i !== e.flag ||
              status_i !== e.status) begin
            $display("%0t: mismatch expected lo=%h hi=%h flag=%b status=%0d", $time,
                     e.lo, e.hi, e.flag, e.status);
            $display("%0t:          actual   lo=%h hi=%h flag=%b status=%0d", $time,
                     res_low_i, res_high_i, test_flag_i, status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb.sv =====
// Stimulus and verdict of the interval arithmetic unit test bench.
module tb;
  import iau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam data_t DMAX = 32'sh7FFF_FFFF;
  localparam data_t DMIN = 32'sh8000_0000;
  localparam data_t ONE  = 32'sh0001_0000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [4:0] cmd = '0;
  data_t      a_low = '0, a_high = '0, b_low = '0, b_high = '0, point_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  data_t      res_low, res_high;
  logic       test_flag;
  logic [2:0] status;
  int         fail_count, pending;
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  interval_arithmetic_unit u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .a_low_i(a_low), .a_high_i(a_high), .b_low_i(b_low), .b_high_i(b_high),
    .point_value_i(point_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .res_low_o(res_low), .res_high_o(res_high), .test_flag_o(test_flag), .status_o(status)
  );

  iau_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .cmd_i(cmd), .a_low_i(a_low), .a_high_i(a_high), .b_low_i(b_low), .b_high_i(b_high),
    .point_value_i(point_value),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .res_low_i(res_low), .res_high_i(res_high), .test_flag_i(test_flag), .status_i(status),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  task automatic send_interval(logic [4:0] c, data_t al, data_t ah, data_t bl, data_t bh,
                               data_t pt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    a_low       <= al;
    a_high      <= ah;
    b_low       <= bl;
    b_high      <= bh;
    point_value <= pt;
    @(negedge clk_i);
    while (!in_ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic data_t rand_bound();
    data_t v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 1) ? DMAX - data_t'($urandom_range(0, 3)) :
                                    DMIN + data_t'($urandom_range(0, 3));
      2: v = data_t'($urandom_range(0, 8)) * ONE - 4 * ONE;
      default: v = data_t'($signed($urandom) >>> $urandom_range(4, 20));
    endcase
    return v;
  endfunction

  task automatic send_random();
    logic [4:0] c;
    data_t al, ah, bl, bh, pt, t;
    c  = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
    al = rand_bound();
    ah = rand_bound();
    bl = rand_bound();
    bh = rand_bound();
    pt = ($urandom_range(0, 1) == 0) ? rand_bound() : al + data_t'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) != 0) begin
      if (al > ah) begin t = al; al = ah; ah = t; end
      if (bl > bh) begin t = bl; bl = bh; bh = t; end
      if (c == CMD_DIV && bl <= 0 && bh >= 0 && $urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) == 0) bl = data_t'($urandom_range(1, 1 << 20));
        else bh = -data_t'($urandom_range(1, 1 << 20));
        if (bl > bh) begin t = bl; bl = bh; bh = t; end
      end
    end
    send_interval(c, al, ah, bl, bh, pt);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni === 1'b0) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_interval(CMD_ADD, ONE, DMAX, ONE, DMAX, 0);
    send_interval(CMD_ADD, DMIN, 0, DMIN, -ONE, 0);
    send_interval(CMD_SUB, DMIN, DMAX, DMIN, DMAX, 0);
    send_interval(CMD_MUL, DMIN, DMAX, DMIN, DMAX, 0);
    send_interval(CMD_MUL, -3, 5, -7, 1, 0);
    send_interval(CMD_DIV, ONE, 3 * ONE, 3 * ONE, 7 * ONE, 0);
    send_interval(CMD_DIV, DMIN, DMAX, 1, 1, 0);
    send_interval(CMD_DIV, ONE, ONE, -ONE, ONE, 0);
    send_interval(CMD_NEG, DMIN, DMAX, 0, 0, 0);
    send_interval(CMD_WIDTH, DMIN, DMAX, 0, 0, 0);
    send_interval(CMD_MID, DMIN, DMAX - 2, 0, 0, 0);
    send_interval(CMD_MID, -3, -3, 0, 0, 0);
    send_interval(CMD_EQ, ONE, 2 * ONE, ONE, 2 * ONE, 0);
    send_interval(CMD_LT, 0, ONE, ONE, 2 * ONE, 0);
    send_interval(CMD_LE, 0, ONE, ONE, 2 * ONE, 0);
    send_interval(CMD_GT, ONE, 2 * ONE, 0, ONE, 0);
    send_interval(CMD_GE, ONE, 2 * ONE, 0, ONE, 0);
    send_interval(CMD_OVERLAP, 0, ONE, ONE, 2 * ONE, 0);
    send_interval(CMD_CONTAINS, DMIN, DMAX, 0, ONE, 0);
    send_interval(CMD_POINT, DMIN, DMAX, 0, 0, DMAX);
    send_interval(CMD_INTERSECT, 0, ONE, 2 * ONE, 3 * ONE, 0);
    send_interval(CMD_INTERSECT, 0, 2 * ONE, ONE, 3 * ONE, 0);
    send_interval(CMD_UNION, DMIN, 0, 0, DMAX, 0);
    send_interval(CMD_ADD, ONE, 0, 0, ONE, 0);
    send_interval(CMD_UNION, 0, ONE, ONE, 0, 0);
    send_interval(5'd31, ONE, 2 * ONE, 0, ONE, DMIN);

    for (int i = 0; i < 1850; i++) begin
      if (i == 600) hold_req = 1'b1;
      if (i == 1600) idle_on = 1'b0;
      send_random();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
